// ===== rtl/core/fcm_pkg.sv =====
// Shared constants, tables and register codes for the Fresnel chirp multiply unit.
package fcm_pkg;

  localparam int SAMPLE_BITS   = 24;
  localparam int POS_BITS      = 10;
  localparam int SIZE_BITS     = 11;
  localparam int STEP_BITS     = 48;
  localparam int SCALE_BITS    = 18;
  localparam int MAX_SIZE      = 1024;
  localparam int PHASE_BITS    = 48;
  localparam int CORDIC_STAGES = 20;

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 48;

  localparam logic [SIZE_BITS-1:0]  SIZE_RESET  = 11'd1024;
  localparam logic [SCALE_BITS-1:0] SCALE_RESET = 18'd131072;

  localparam logic [31:0] TWO_PI_Q29      = 32'd3373259426;
  localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;

  localparam logic [31:0] ATAN_Q30 [0:31] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001, 32'h00000000
  };

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_FORWARD = 3'd0,
    CFG_STEP_X  = 3'd1,
    CFG_STEP_Y  = 3'd2,
    CFG_SCALE   = 3'd3,
    CFG_SIZE_X  = 3'd4,
    CFG_SIZE_Y  = 3'd5
  } cfg_idx_e;

endpackage

// ===== rtl/core/fresnel_chirp_multiply_unit.sv =====
// Top level: pipelined Fresnel chirp multiply of a complex pixel stream.
//
// Channel | Direction | Handshake              | Payload
// in      | sink      | in_valid_i/in_ready_o  | pos_x_i pos_y_i in_real_i in_imag_i
// out     | source    | out_valid_o/out_ready_i| out_real_o out_imag_o out_saturated_o
// cfg     | sink      | cfg_we_i               | cfg_idx_i cfg_data_i
//
// One request per cycle while the pipeline advances; the latency grows with the CORDIC chain length.
// The whole pipeline advances when the output register is empty or taken.
// A stall holds every stage; nothing is dropped or repeated.
// Reset clears the valid bits and loads the register defaults.
module fresnel_chirp_multiply_unit
  import fcm_pkg::*;
#(
  parameter int PHASE_W  = PHASE_BITS,
  parameter int N_STAGES = CORDIC_STAGES
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]         cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0]        cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [POS_BITS-1:0]             pos_x_i,
  input  logic [POS_BITS-1:0]             pos_y_i,
  input  logic signed [SAMPLE_BITS-1:0]   in_real_i,
  input  logic signed [SAMPLE_BITS-1:0]   in_imag_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]   out_real_o,
  output logic signed [SAMPLE_BITS-1:0]   out_imag_o,
  output logic                            out_saturated_o
);

  localparam int DW   = SIZE_BITS;
  localparam int SQW  = 2 * DW;
  localparam int HW   = STEP_BITS / 2;
  localparam int LOW  = HW + SQW;
  localparam int CW   = 34;
  localparam int PW   = 62;
  localparam int NPW  = CW + SCALE_BITS + 1;
  localparam int CRW  = 28;
  localparam int MPW  = SAMPLE_BITS + CRW;
  localparam int SW   = MPW + 1;
  localparam int RW   = SW - SAMPLE_BITS;
  localparam int L    = 7 + N_STAGES;
  localparam int TOT  = L + 6;
  localparam logic [STEP_BITS-1:0] PMASK = {STEP_BITS{1'b1}} << (STEP_BITS - PHASE_W);
  localparam logic signed [RW-1:0] SAT_HI = RW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [RW-1:0] SAT_LO = -SAT_HI - RW'(1);

  logic                   fwd_q;
  logic [STEP_BITS-1:0]   step_x_q, step_y_q;
  logic [SCALE_BITS-1:0]  scale_q;
  logic [SIZE_BITS-1:0]   size_x_q, size_y_q;
  logic [SIZE_BITS-1:0]   size_lim;

  assign size_lim = (cfg_data_i[SIZE_BITS-1:0] > SIZE_BITS'(MAX_SIZE)) ?
                    SIZE_BITS'(MAX_SIZE) : cfg_data_i[SIZE_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q    <= 1'b0;
      step_x_q <= '0;
      step_y_q <= '0;
      scale_q  <= SCALE_RESET;
      size_x_q <= SIZE_RESET;
      size_y_q <= SIZE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FORWARD: fwd_q    <= cfg_data_i[0];
        CFG_STEP_X:  step_x_q <= cfg_data_i[STEP_BITS-1:0];
        CFG_STEP_Y:  step_y_q <= cfg_data_i[STEP_BITS-1:0];
        CFG_SCALE:   scale_q  <= cfg_data_i[SCALE_BITS-1:0];
        CFG_SIZE_X:  size_x_q <= size_lim;
        CFG_SIZE_Y:  size_y_q <= size_lim;
        default: ;
      endcase
    end
  end

  logic           en;
  logic [TOT-1:0] v_q;

  assign en         = !v_q[TOT-1] || out_ready_i;
  assign in_ready_o = en;
  assign out_valid_o = v_q[TOT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[TOT-2:0], in_valid_i};
    end
  end

  // carry samples alongside the phase path
  logic signed [SAMPLE_BITS-1:0] a_q [0:L+2];
  logic signed [SAMPLE_BITS-1:0] b_q [0:L+2];

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q[0] <= in_real_i;
      b_q[0] <= in_imag_i;
      for (int k = 1; k <= L + 2; k++) begin
        a_q[k] <= a_q[k-1];
        b_q[k] <= b_q[k-1];
      end
    end
  end

  // stage 0: doubled distances
  logic signed [DW+1:0] dx_s, dy_s;
  logic [DW-1:0]        dx_q, dy_q;

  assign dx_s = $signed({1'b0, pos_x_i, 1'b0}) - ($signed({1'b0, size_x_q}) - (DW+2)'(1));
  assign dy_s = $signed({1'b0, pos_y_i, 1'b0}) - ($signed({1'b0, size_y_q}) - (DW+2)'(1));

  // stage 1: squares; stage 2: partial products; stage 3: phase sum
  logic [SQW-1:0]       sqx_q, sqy_q;
  logic [LOW-1:0]       lox_q, loy_q;
  logic [HW-1:0]        hix_q, hiy_q;
  logic [STEP_BITS-1:0] phase_q;
  logic [LOW-1:0]       hix_w, hiy_w;

  assign hix_w = step_x_q[STEP_BITS-1:HW] * sqx_q;
  assign hiy_w = step_y_q[STEP_BITS-1:HW] * sqy_q;

  // stage 4: quadrant and residual magnitude
  logic [STEP_BITS-1:0] pm;
  logic [31:0]          sh;
  logic [1:0]           q4_q;
  logic                 neg4_q;
  logic [29:0]          mag4_q;

  assign pm = phase_q & PMASK;
  assign sh = pm[STEP_BITS-1:16] + 32'h2000_0000;

  // stage 5: radian scaling product; stage 6: rounded angle
  logic [1:0]          q5_q;
  logic                neg5_q;
  logic [PW-1:0]       prod5_q;
  logic [PW-1:0]       rnd5;

  assign rnd5 = (prod5_q + (PW'(1) << 30)) >> 31;

  logic signed [CW-1:0] cx_q [0:N_STAGES];
  logic signed [CW-1:0] cy_q [0:N_STAGES];
  logic signed [CW-1:0] cz_q [0:N_STAGES];
  logic [1:0]           cq_q [0:N_STAGES];

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q    <= dx_s[DW+1] ? DW'(-dx_s) : DW'(dx_s);
      dy_q    <= dy_s[DW+1] ? DW'(-dy_s) : DW'(dy_s);
      sqx_q   <= dx_q * dx_q;
      sqy_q   <= dy_q * dy_q;
      lox_q   <= step_x_q[HW-1:0] * sqx_q;
      loy_q   <= step_y_q[HW-1:0] * sqy_q;
      hix_q   <= hix_w[HW-1:0];
      hiy_q   <= hiy_w[HW-1:0];
      phase_q <= STEP_BITS'(lox_q) + STEP_BITS'(loy_q) +
                 {hix_q + hiy_q, {HW{1'b0}}};
      q4_q    <= sh[31:30];
      neg4_q  <= !sh[29];
      mag4_q  <= sh[29] ? {1'b0, sh[28:0]} : (30'h2000_0000 - {1'b0, sh[28:0]});
      q5_q    <= q4_q;
      neg5_q  <= neg4_q;
      prod5_q <= PW'(mag4_q) * PW'(TWO_PI_Q29);
      cx_q[0] <= CW'(CORDIC_GAIN_Q30);
      cy_q[0] <= '0;
      cz_q[0] <= neg5_q ? -$signed(CW'(rnd5)) : $signed(CW'(rnd5));
      cq_q[0] <= q5_q;
    end
  end

  for (genvar k = 0; k < N_STAGES; k++) begin : g_cordic
    localparam logic signed [CW-1:0] ATAN_K = CW'(ATAN_Q30[k]);
    always_ff @(posedge clk_i) begin
      if (en) begin
        cq_q[k+1] <= cq_q[k];
        if (!cz_q[k][CW-1]) begin
          cx_q[k+1] <= cx_q[k] - (cy_q[k] >>> k);
          cy_q[k+1] <= cy_q[k] + (cx_q[k] >>> k);
          cz_q[k+1] <= cz_q[k] - ATAN_K;
        end else begin
          cx_q[k+1] <= cx_q[k] + (cy_q[k] >>> k);
          cy_q[k+1] <= cy_q[k] - (cx_q[k] >>> k);
          cz_q[k+1] <= cz_q[k] + ATAN_K;
        end
      end
    end
  end

  // quadrant map, coefficient, product, round, saturate
  logic signed [CW-1:0]  sin_q, cos_q;
  logic signed [NPW-1:0] sn_q, cn_q;
  logic signed [CRW-1:0] cr_q, ci_q;
  logic signed [NPW-1:0] ci_pre;
  logic signed [MPW-1:0] ac_q, bc_q, ai_q, bi_q;
  logic signed [RW-1:0]  re_q, im_q;
  logic signed [SW-1:0]  re_sum, im_sum;
  logic signed [CW-1:0]  xe, ye;
  logic [1:0]            qe;

  assign xe = cx_q[N_STAGES];
  assign ye = cy_q[N_STAGES];
  assign qe = cq_q[N_STAGES];
  assign ci_pre = (-cn_q + NPW'(1 << 22)) >>> 23;
  assign re_sum = SW'(ac_q) - SW'(bi_q) + SW'(1 << 23);
  assign im_sum = SW'(bc_q) + SW'(ai_q) + SW'(1 << 23);

  always_ff @(posedge clk_i) begin
    if (en) begin
      unique case (qe)
        2'd0: begin sin_q <= ye;  cos_q <= xe;  end
        2'd1: begin sin_q <= xe;  cos_q <= -ye; end
        2'd2: begin sin_q <= -ye; cos_q <= -xe; end
        default: begin sin_q <= -xe; cos_q <= ye; end
      endcase
      sn_q <= NPW'(sin_q) * $signed({1'b0, scale_q});
      cn_q <= NPW'(cos_q) * $signed({1'b0, scale_q});
      cr_q <= CRW'((sn_q + NPW'(1 << 22)) >>> 23);
      ci_q <= fwd_q ? -CRW'(ci_pre) : CRW'(ci_pre);
      ac_q <= MPW'(a_q[L+2]) * MPW'(cr_q);
      bc_q <= MPW'(b_q[L+2]) * MPW'(cr_q);
      ai_q <= MPW'(a_q[L+2]) * MPW'(ci_q);
      bi_q <= MPW'(b_q[L+2]) * MPW'(ci_q);
      re_q <= RW'(re_sum >>> 24);
      im_q <= RW'(im_sum >>> 24);
      out_real_o <= (re_q > SAT_HI) ? SAMPLE_BITS'(SAT_HI) :
                    (re_q < SAT_LO) ? SAMPLE_BITS'(SAT_LO) : SAMPLE_BITS'(re_q);
      out_imag_o <= (im_q > SAT_HI) ? SAMPLE_BITS'(SAT_HI) :
                    (im_q < SAT_LO) ? SAMPLE_BITS'(SAT_LO) : SAMPLE_BITS'(im_q);
      out_saturated_o <= (re_q > SAT_HI) || (re_q < SAT_LO) ||
                         (im_q > SAT_HI) || (im_q < SAT_LO);
    end
  end

endmodule
